// File: rtl/tls_pkg.sv
// Shared constants and record type for the text line splitter.
`timescale 1ns / 1ps

package tls_pkg;

  // Counter widths
  localparam int OFFSET_BITS = 24;
  localparam int LENGTH_BITS = 16;

  // Result field widths
  localparam int IDX_W   = 24;
  localparam int START_W = 24;
  localparam int LEN_W   = 16;
  localparam int FNW_W   = 16;

  // Stream payload widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_FIELD_W = IDX_W + START_W + LEN_W + FNW_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 2;

  // Character codes
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;

  // Output queue sizing
  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef logic [OFFSET_BITS-1:0] off_t;
  typedef logic [LENGTH_BITS-1:0] len_t;

  // One line record
  typedef struct packed {
    logic               last_line;
    logic               saturated;
    logic               is_text;
    logic [FNW_W-1:0]   first_nonwhite;
    logic [LEN_W-1:0]   line_length;
    logic [START_W-1:0] line_start;
    logic [IDX_W-1:0]   line_index;
  } tls_rec_t;

endpackage

// File: rtl/text_line_splitter_core.sv
// Line splitter core: byte stream in, one record per text line out.
`timescale 1ns / 1ps

// Channel   Dir  Signals                              Payload
// in        in   in_tvalid/in_tready/in_tdata/user/last   byte, has_byte, end_of_buffer
// out       out  out_tvalid/out_tready/out_tdata/user/last line record
// cfg       in   cfg_valid/cfg_ready/cfg_data          preserve_cr
//
// One byte is taken per cycle while in_tready is high; an item is held in the input register,
// then its records (zero, one or two) land in an 8-entry output queue.
// An item ending on LF plus end of buffer gives two records.
// in_tready drops only while the output queue is near full (downstream stall).
// Reset (rst_n low, synchronous) empties the queue and clears all counters.

module text_line_splitter_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tls_pkg::IN_TDATA_W-1:0]    in_tdata,   // [7:0] data_byte
  input  logic                              in_tuser,   // [0] has_byte
  input  logic                              in_tlast,   // end_of_buffer
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tls_pkg::OUT_TDATA_W-1:0]   out_tdata,  // line_index, line_start,
                                                        // line_length, first_nonwhite
  output logic [tls_pkg::OUT_TUSER_W-1:0]   out_tuser,  // [0] is_text, [1] saturated
  output logic                              out_tlast,  // last_line
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_data    // preserve_cr
);
  import tls_pkg::*;

  localparam off_t OFF_MAX = '1;
  localparam len_t LEN_MAX = '1;

  // Build a record from line state
  function automatic tls_rec_t make_rec(off_t idx, off_t start, len_t len, len_t trail,
                                        len_t lead, logic text, logic sat, logic last,
                                        logic keep_cr);
    tls_rec_t r;
    len_t     l;
    l = len;
    if (!keep_cr) begin
      l = (trail >= len) ? '0 : len - trail;
    end
    r.line_index     = IDX_W'(idx);
    r.line_start     = START_W'(start);
    r.line_length    = LEN_W'(l);
    r.first_nonwhite = FNW_W'((lead < l) ? lead : l);
    r.is_text        = text;
    r.saturated      = sat;
    r.last_line      = last;
    return r;
  endfunction

  // Configuration
  logic preserve_cr_r;

  // Input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_has_r;
  logic       in_last_r;

  // Line and buffer state
  off_t off_r, off_nxt;
  off_t start_r, start_nxt;
  off_t idx_r, idx_nxt;
  len_t len_r, len_nxt;
  len_t trail_r, trail_nxt;
  len_t lead_r, lead_nxt;
  logic nws_r, nws_nxt;
  logic text_r, text_nxt;
  logic sat_r, sat_nxt;

  // Output queue
  tls_rec_t             oq_mem [OQ_DEPTH];
  logic [OQ_AW-1:0]     head_r, tail_r;
  logic [OQ_CW-1:0]     count_r;
  logic [OQ_CW:0]       need;

  // Step results
  off_t     off1, start1, idx1;
  len_t     len1, trail1, lead1;
  logic     nws1, text1, sat1, white;
  logic     push_a, push_b, pop;
  tls_rec_t rec_a, rec_b;
  logic [1:0] push_n;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign pop       = out_tvalid && out_tready;
  // Room for the pending item and the new one, two records each at worst
  assign need      = {1'b0, count_r} + (in_valid_r ? (OQ_CW+1)'(4) : (OQ_CW+1)'(2));
  assign in_tready = (need <= (OQ_CW+1)'(OQ_DEPTH));

  // Per-byte update of line state
  always_comb begin
    off1   = off_r;
    start1 = start_r;
    idx1   = idx_r;
    len1   = len_r;
    trail1 = trail_r;
    lead1  = lead_r;
    nws1   = nws_r;
    text1  = text_r;
    sat1   = sat_r;
    push_a = 1'b0;
    rec_a  = '0;
    white  = (in_byte_r == CH_SP) || (in_byte_r == CH_TAB) || (in_byte_r == CH_CR);
    if (in_valid_r && in_has_r) begin
      if (off_r == OFF_MAX) sat1 = 1'b1;
      else off1 = off_r + 1'b1;
      if (in_byte_r == CH_LF) begin
        push_a = 1'b1;
        rec_a  = make_rec(idx_r, start_r, len_r, trail_r, lead_r, text_r, sat1, 1'b0,
                          preserve_cr_r);
        if (idx_r == OFF_MAX) sat1 = 1'b1;
        else idx1 = idx_r + 1'b1;
        start1 = off1;
        len1   = '0;
        trail1 = '0;
        lead1  = '0;
        nws1   = 1'b0;
      end else begin
        if (in_byte_r == CH_NUL) text1 = 1'b0;
        if (len_r == LEN_MAX) sat1 = 1'b1;
        else len1 = len_r + 1'b1;
        if (in_byte_r == CH_CR) begin
          if (trail_r == LEN_MAX) sat1 = 1'b1;
          else trail1 = trail_r + 1'b1;
        end else begin
          trail1 = '0;
        end
        if (!nws_r && white) begin
          if (lead_r == LEN_MAX) sat1 = 1'b1;
          else lead1 = lead_r + 1'b1;
        end else begin
          nws1 = 1'b1;
        end
      end
    end
    // End of buffer: final record from updated state
    push_b = in_valid_r && in_last_r;
    rec_b  = make_rec(idx1, start1, len1, trail1, lead1, text1, sat1, 1'b1, preserve_cr_r);
    push_n = {1'b0, push_a} + {1'b0, push_b};
    if (push_b) begin
      off_nxt   = '0;
      start_nxt = '0;
      idx_nxt   = '0;
      len_nxt   = '0;
      trail_nxt = '0;
      lead_nxt  = '0;
      nws_nxt   = 1'b0;
      text_nxt  = 1'b1;
      sat_nxt   = 1'b0;
    end else begin
      off_nxt   = off1;
      start_nxt = start1;
      idx_nxt   = idx1;
      len_nxt   = len1;
      trail_nxt = trail1;
      lead_nxt  = lead1;
      nws_nxt   = nws1;
      text_nxt  = text1;
      sat_nxt   = sat1;
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preserve_cr_r <= 1'b0;
      in_valid_r    <= 1'b0;
      off_r         <= '0;
      start_r       <= '0;
      idx_r         <= '0;
      len_r         <= '0;
      trail_r       <= '0;
      lead_r        <= '0;
      nws_r         <= 1'b0;
      text_r        <= 1'b1;
      sat_r         <= 1'b0;
      head_r        <= '0;
      tail_r        <= '0;
      count_r       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) preserve_cr_r <= cfg_data;
      in_valid_r <= in_tvalid && in_tready;
      off_r      <= off_nxt;
      start_r    <= start_nxt;
      idx_r      <= idx_nxt;
      len_r      <= len_nxt;
      trail_r    <= trail_nxt;
      lead_r     <= lead_nxt;
      nws_r      <= nws_nxt;
      text_r     <= text_nxt;
      sat_r      <= sat_nxt;
      tail_r     <= tail_r + OQ_AW'(push_n);
      if (pop) head_r <= head_r + 1'b1;
      count_r    <= count_r + OQ_CW'(push_n) - OQ_CW'(pop);
    end
  end

  // Input payload register
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata[7:0];
      in_has_r  <= in_tuser;
      in_last_r <= in_tlast;
    end
  end

  // Queue writes: first record at tail, second right after it
  always_ff @(posedge clk) begin
    if (push_a || push_b) oq_mem[tail_r] <= push_a ? rec_a : rec_b;
    if (push_a && push_b) oq_mem[tail_r + 1'b1] <= rec_b;
  end

  // Output side
  assign out_tvalid = (count_r != '0);
  assign out_tdata  = OUT_TDATA_W'({oq_mem[head_r].first_nonwhite,
                                    oq_mem[head_r].line_length,
                                    oq_mem[head_r].line_start,
                                    oq_mem[head_r].line_index});
  assign out_tuser  = {oq_mem[head_r].saturated, oq_mem[head_r].is_text};
  assign out_tlast  = oq_mem[head_r].last_line;

`ifndef SYNTHESIS
  // Queue never overfills
  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= OQ_CW'(OQ_DEPTH))
    else $error("output queue overflow");

  // A pending item always finds room for two records
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r |-> (count_r <= OQ_CW'(OQ_DEPTH - 2)))
    else $error("pending item without queue room");

  // End of buffer returns buffer state to its start values
  a_buf_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && in_last_r) |=> (off_r == '0 && idx_r == '0 && text_r && !sat_r))
    else $error("buffer state not cleared after end of buffer");

  // Records pushed show up in the count
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push_a && push_b && !pop) |=> (count_r == $past(count_r) + OQ_CW'(2)))
    else $error("queue count mismatch on double push");
`endif

endmodule
